// ===== hw/rtl/pect_pkg.sv =====
// Shared types and constants for the polygon ear-clip triangulator.
// No dependencies; every other file of the block but pect_ram imports this package.
`timescale 1ns / 1ps

package pect_pkg;

  // Vertex store geometry.
  localparam int MAX_PTS  = 32;
  localparam int IDX_W    = $clog2(MAX_PTS);
  localparam int CNT_W    = IDX_W + 1;

  // Coordinate and arithmetic widths.
  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int AREA_W   = 40;
  localparam int CMP_W    = AREA_W + 1;
  localparam int SHIFT_W  = 6;

  localparam logic [SHIFT_W-1:0] TOL_SHIFT_RESET = SHIFT_W'(20);

  // One stored vertex.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  // One buffered ear triangle.
  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } tri_t;

endpackage

// ===== hw/rtl/pect_point_if.sv =====
// Valid/ready channel that carries one polygon vertex per beat.
// Depends on pect_pkg for the coordinate width.
`timescale 1ns / 1ps

interface pect_point_if import pect_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

// ===== hw/rtl/pect_tri_if.sv =====
// Valid/ready channel that carries one output triangle per beat.
// Depends on pect_pkg for the corner index width.
`timescale 1ns / 1ps

interface pect_tri_if import pect_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] corner_a;
  logic [IDX_W-1:0] corner_b;
  logic [IDX_W-1:0] corner_c;
  logic             used_fan;
  logic             points_dropped;
  logic             last_triangle;

  modport source (output valid, corner_a, corner_b, corner_c, used_fan, points_dropped,
                  last_triangle, input ready);
  modport sink   (input valid, corner_a, corner_b, corner_c, used_fan, points_dropped,
                  last_triangle, output ready);
endinterface

// ===== hw/rtl/pect_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pect_cross.sv =====
// Three-stage pipelined 2D cross product (a - o) x (b - o).
// Depends on pect_pkg for point_t and the arithmetic widths.
`timescale 1ns / 1ps

module pect_cross import pect_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  point_t                     o,
  input  point_t                     a,
  input  point_t                     b,
  output logic                       done,
  output logic signed [CROSS_W-1:0]  result
);

  logic                      v1, v2;
  logic signed [DIFF_W-1:0]  dax, day, dbx, dby;
  logic signed [PROD_W-1:0]  p1, p2;

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  // Differences, products, final subtract.
  always_ff @(posedge clk) begin
    dax    <= DIFF_W'(a.x) - DIFF_W'(o.x);
    day    <= DIFF_W'(a.y) - DIFF_W'(o.y);
    dbx    <= DIFF_W'(b.x) - DIFF_W'(o.x);
    dby    <= DIFF_W'(b.y) - DIFF_W'(o.y);
    p1     <= dax * dby;
    p2     <= day * dbx;
    result <= CROSS_W'(p1) - CROSS_W'(p2);
  end

endmodule

// ===== hw/rtl/polygon_ear_clip_triangulator_unit.sv =====
// Top level of the polygon ear-clip triangulator: control sequencer and memories.
// Depends on pect_pkg, pect_point_if, pect_tri_if, pect_ram and pect_cross.
`timescale 1ns / 1ps

// A vertex beat is taken whenever the block is idle; up to 32 points are kept and
// further points of the loop are dropped and flagged. The beat marked last starts the
// triangulation when at least three points are stored, and the block takes no vertex
// until the loop's triangles are all queued. Work is paced by one cross product at a
// time: a step that sets up the operands, then three vertex memory reads that feed a
// three-stage multiply pipe. For n points the doubled area takes one cross product per
// point and the convexity check up to one per point; ear clipping adds one cross product
// per candidate corner plus up to three per other ring point tested against it, which is
// of order n^3 products in the worst case. Fan triangles leave at one per cycle when the
// output side is ready; ear triangles leave more slowly, as each is first read from the ear buffer.
module polygon_ear_clip_triangulator_unit import pect_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [SHIFT_W-1:0] cfg_write_data,
  pect_point_if.sink         points,
  pect_tri_if.source         triangles
);

  // Sequencer states.
  localparam int STATE_W = 5;
  localparam logic [STATE_W-1:0] S_IDLE     = 5'd0;
  localparam logic [STATE_W-1:0] S_AREA_SET = 5'd1;
  localparam logic [STATE_W-1:0] S_LD0      = 5'd2;
  localparam logic [STATE_W-1:0] S_LD1      = 5'd3;
  localparam logic [STATE_W-1:0] S_LD2      = 5'd4;
  localparam logic [STATE_W-1:0] S_LD3      = 5'd5;
  localparam logic [STATE_W-1:0] S_CWAIT    = 5'd6;
  localparam logic [STATE_W-1:0] S_TOL      = 5'd7;
  localparam logic [STATE_W-1:0] S_CVX_SET  = 5'd8;
  localparam logic [STATE_W-1:0] S_INIT     = 5'd9;
  localparam logic [STATE_W-1:0] S_OUTER    = 5'd10;
  localparam logic [STATE_W-1:0] S_PASS_RD  = 5'd11;
  localparam logic [STATE_W-1:0] S_PASS_CAP = 5'd12;
  localparam logic [STATE_W-1:0] S_IN_CHK   = 5'd13;
  localparam logic [STATE_W-1:0] S_IN_NX    = 5'd14;
  localparam logic [STATE_W-1:0] S_IN_NXC   = 5'd15;
  localparam logic [STATE_W-1:0] S_REMOVE   = 5'd16;
  localparam logic [STATE_W-1:0] S_FIN0     = 5'd17;
  localparam logic [STATE_W-1:0] S_FIN1     = 5'd18;
  localparam logic [STATE_W-1:0] S_FIN2     = 5'd19;
  localparam logic [STATE_W-1:0] S_EM_RD    = 5'd20;
  localparam logic [STATE_W-1:0] S_EM_PUT   = 5'd21;
  localparam logic [STATE_W-1:0] S_FAN      = 5'd22;
  localparam logic [STATE_W-1:0] S_DONE     = 5'd23;

  // What the pending cross product is for.
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PH_AREA  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_CVX   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_EAR   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_IN1   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_IN2   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_IN3   = 3'd5;
  localparam logic [PHASE_W-1:0] PH_FINAL = 3'd6;

  logic [STATE_W-1:0]       state;
  logic [PHASE_W-1:0]       phase;
  logic [SHIFT_W-1:0]       tol_shift;
  logic [CNT_W-1:0]         n, n_eff, i, pos, k, rlen, ears, e;
  logic                     ovf, orient_neg, rec;
  logic signed [AREA_W-1:0] area;
  logic [AREA_W-1:0]        tol, mag;
  logic [IDX_W-1:0]         lo, la, lb, ia, ib, ic, q, head, tail;
  point_t                   co, ca;

  logic                     in_fire, out_free;
  logic                     out_valid;
  logic [IDX_W-1:0]         out_a, out_b, out_c;
  logic                     out_fan, out_drop, out_last;

  // Memory ports.
  logic                     pt_we;
  logic [IDX_W-1:0]         pt_raddr;
  point_t                   pt_wdata, pt_rdata;
  logic                     nx_we;
  logic [IDX_W-1:0]         nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic                     ear_we;
  tri_t                     ear_wdata, ear_rdata;

  // Cross product unit.
  logic                      cr_valid;
  logic signed [CROSS_W-1:0] cr;
  logic signed [CMP_W-1:0]   cr_ext, cr_abs, t, tol_s, neg_tol;
  logic                      t_lt, t_le, t_ge, keep_final;
  logic [IDX_W-1:0]          nxt_i, prv_i;
  logic                      adv_last;

  assign in_fire  = points.valid && points.ready;
  assign out_free = !out_valid || triangles.ready;
  assign points.ready = (state == S_IDLE);

  assign triangles.valid          = out_valid;
  assign triangles.corner_a       = out_a;
  assign triangles.corner_b       = out_b;
  assign triangles.corner_c       = out_c;
  assign triangles.used_fan       = out_fan;
  assign triangles.points_dropped = out_drop;
  assign triangles.last_triangle  = out_last;

  // Point count after the current beat is stored.
  assign n_eff = (n < CNT_W'(MAX_PTS)) ? n + CNT_W'(1) : n;

  // Circular neighbors of loop index i.
  assign nxt_i = (i == n - CNT_W'(1)) ? '0 : IDX_W'(i + CNT_W'(1));
  assign prv_i = (i == '0) ? IDX_W'(n - CNT_W'(1)) : IDX_W'(i - CNT_W'(1));

  // Oriented value and tolerance compares.
  assign cr_ext     = CMP_W'(cr);
  assign cr_abs     = (cr_ext < 0) ? -cr_ext : cr_ext;
  assign t          = orient_neg ? -cr_ext : cr_ext;
  assign tol_s      = signed'({1'b0, tol});
  assign neg_tol    = -tol_s;
  assign t_lt       = (t < neg_tol);
  assign t_le       = (t <= tol_s);
  assign t_ge       = (t >= neg_tol);
  assign keep_final = (cr_abs > tol_s);
  assign mag        = area[AREA_W-1] ? AREA_W'(-area) : AREA_W'(area);
  assign adv_last   = (pos + CNT_W'(1) == rlen);

  // Vertex store.
  assign pt_we    = in_fire && (n < CNT_W'(MAX_PTS));
  assign pt_wdata = '{x: points.point_x, y: points.point_y};

  always_comb begin
    unique case (state)
      S_LD0:   pt_raddr = lo;
      S_LD1:   pt_raddr = la;
      default: pt_raddr = lb;
    endcase
  end

  pect_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_PTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (IDX_W'(n)),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // Ring of vertex indices, kept as successor links.
  always_comb begin
    nx_we    = (state == S_INIT) || (state == S_REMOVE);
    nx_waddr = (state == S_INIT) ? IDX_W'(i) : ia;
    nx_wdata = (state == S_INIT) ? nxt_i : ic;
    unique case (state)
      S_IN_NX: nx_raddr = q;
      S_FIN0:  nx_raddr = head;
      S_FIN1:  nx_raddr = nx_rdata;
      default: nx_raddr = ib;
    endcase
  end

  pect_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PTS)) u_ring_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  // Ear buffer: both the clipped ears and the closing triangle come from ia, ib, ic.
  assign ear_we = ((state == S_REMOVE) && rec) ||
                  ((state == S_CWAIT) && cr_valid && (phase == PH_FINAL) && keep_final);
  assign ear_wdata = '{a: ia, b: ib, c: ic};

  pect_ram #(.WIDTH($bits(tri_t)), .DEPTH(MAX_PTS)) u_ear_ram (
    .clk   (clk),
    .we    (ear_we),
    .waddr (IDX_W'(ears)),
    .wdata (ear_wdata),
    .raddr (IDX_W'(e)),
    .rdata (ear_rdata)
  );

  pect_cross u_cross (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_LD3),
    .o      (co),
    .a      (ca),
    .b      (pt_rdata),
    .done   (cr_valid),
    .result (cr)
  );

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      tol_shift <= TOL_SHIFT_RESET;
    end else begin
      if (cfg_write_en) begin
        tol_shift <= cfg_write_data;
      end
      if (out_valid && triangles.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        // Collect vertices; the last one starts the work when at least three are stored.
        S_IDLE: begin
          if (in_fire) begin
            if (n < CNT_W'(MAX_PTS)) begin
              n <= n + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (points.last_point) begin
              if (n_eff >= CNT_W'(3)) begin
                i     <= '0;
                area  <= '0;
                state <= S_AREA_SET;
              end else begin
                n   <= '0;
                ovf <= 1'b0;
              end
            end
          end
        end

        S_AREA_SET: begin
          la    <= IDX_W'(i);
          lb    <= nxt_i;
          phase <= PH_AREA;
          state <= S_LD0;
        end

        // Fetch three points and start one cross product.
        S_LD0: state <= S_LD1;
        S_LD1: begin
          co    <= (phase == PH_AREA) ? '0 : pt_rdata;
          state <= S_LD2;
        end
        S_LD2: begin
          ca    <= pt_rdata;
          state <= S_LD3;
        end
        S_LD3: state <= S_CWAIT;

        // Act on the finished cross product.
        S_CWAIT: begin
          if (cr_valid) begin
            unique case (phase)
              PH_AREA: begin
                area <= area + AREA_W'(cr);
                if (i == n - CNT_W'(1)) begin
                  state <= S_TOL;
                end else begin
                  i     <= i + CNT_W'(1);
                  state <= S_AREA_SET;
                end
              end
              PH_CVX: begin
                if (t_lt) begin
                  i     <= '0;
                  state <= S_INIT;
                end else if (i == n - CNT_W'(1)) begin
                  i     <= CNT_W'(1);
                  state <= S_FAN;
                end else begin
                  i     <= i + CNT_W'(1);
                  state <= S_CVX_SET;
                end
              end
              PH_EAR: begin
                if (t_lt) begin
                  if (adv_last) begin
                    i     <= CNT_W'(1);
                    state <= S_FAN;
                  end else begin
                    pos   <= pos + CNT_W'(1);
                    ia    <= ib;
                    ib    <= ic;
                    state <= S_PASS_RD;
                  end
                end else if (t_le) begin
                  rec   <= 1'b0;
                  state <= S_REMOVE;
                end else begin
                  k     <= '0;
                  q     <= head;
                  state <= S_IN_CHK;
                end
              end
              PH_IN1: begin
                if (t_ge) begin
                  lo    <= ib;
                  la    <= ic;
                  lb    <= q;
                  phase <= PH_IN2;
                  state <= S_LD0;
                end else begin
                  state <= S_IN_NX;
                end
              end
              PH_IN2: begin
                if (t_ge) begin
                  lo    <= ic;
                  la    <= ia;
                  lb    <= q;
                  phase <= PH_IN3;
                  state <= S_LD0;
                end else begin
                  state <= S_IN_NX;
                end
              end
              PH_IN3: begin
                if (t_ge) begin
                  // A ring point lies in the candidate: try the next corner.
                  if (adv_last) begin
                    i     <= CNT_W'(1);
                    state <= S_FAN;
                  end else begin
                    pos   <= pos + CNT_W'(1);
                    ia    <= ib;
                    ib    <= ic;
                    state <= S_PASS_RD;
                  end
                end else begin
                  state <= S_IN_NX;
                end
              end
              PH_FINAL: begin
                if (keep_final) begin
                  ears <= ears + CNT_W'(1);
                end
                e     <= '0;
                state <= S_EM_RD;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        // Orientation and tolerance from the doubled area; three points go straight to the fan.
        S_TOL: begin
          orient_neg <= area[AREA_W-1];
          tol        <= mag >> tol_shift;
          if (n == CNT_W'(3)) begin
            i     <= CNT_W'(1);
            state <= S_FAN;
          end else begin
            i     <= '0;
            state <= S_CVX_SET;
          end
        end

        S_CVX_SET: begin
          lo    <= prv_i;
          la    <= IDX_W'(i);
          lb    <= nxt_i;
          phase <= PH_CVX;
          state <= S_LD0;
        end

        // Build the ring links, one entry a cycle.
        S_INIT: begin
          if (i == n - CNT_W'(1)) begin
            head  <= '0;
            tail  <= IDX_W'(n - CNT_W'(1));
            rlen  <= n;
            ears  <= '0;
            state <= S_OUTER;
          end else begin
            i <= i + CNT_W'(1);
          end
        end

        // Start a pass over the ring from its first entry, or finish once three entries remain.
        S_OUTER: begin
          if (rlen > CNT_W'(3)) begin
            pos   <= '0;
            ia    <= tail;
            ib    <= head;
            state <= S_PASS_RD;
          end else begin
            state <= S_FIN0;
          end
        end

        S_PASS_RD: state <= S_PASS_CAP;
        S_PASS_CAP: begin
          ic    <= nx_rdata;
          lo    <= ia;
          la    <= ib;
          lb    <= nx_rdata;
          phase <= PH_EAR;
          state <= S_LD0;
        end

        // Walk the ring looking for a point inside the candidate ear.
        S_IN_CHK: begin
          if (k == rlen) begin
            rec   <= 1'b1;
            state <= S_REMOVE;
          end else if ((q == ia) || (q == ib) || (q == ic)) begin
            state <= S_IN_NX;
          end else begin
            lo    <= ia;
            la    <= ib;
            lb    <= q;
            phase <= PH_IN1;
            state <= S_LD0;
          end
        end
        S_IN_NX: state <= S_IN_NXC;
        S_IN_NXC: begin
          q     <= nx_rdata;
          k     <= k + CNT_W'(1);
          state <= S_IN_CHK;
        end

        // Unlink the middle corner, recording it as an ear when asked.
        S_REMOVE: begin
          if (ib == head) begin
            head <= ic;
          end
          if (ib == tail) begin
            tail <= ia;
          end
          rlen <= rlen - CNT_W'(1);
          if (rec) begin
            ears <= ears + CNT_W'(1);
          end
          state <= S_OUTER;
        end

        // Closing triangle from the three remaining ring entries.
        S_FIN0: state <= S_FIN1;
        S_FIN1: begin
          ia    <= head;
          ib    <= nx_rdata;
          state <= S_FIN2;
        end
        S_FIN2: begin
          ic    <= nx_rdata;
          lo    <= ia;
          la    <= ib;
          lb    <= nx_rdata;
          phase <= PH_FINAL;
          state <= S_LD0;
        end

        // Send the buffered ears.
        S_EM_RD: begin
          state <= (ears == '0) ? S_DONE : S_EM_PUT;
        end
        S_EM_PUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_a     <= ear_rdata.a;
            out_b     <= ear_rdata.b;
            out_c     <= ear_rdata.c;
            out_fan   <= 1'b0;
            out_drop  <= ovf;
            out_last  <= (e == ears - CNT_W'(1));
            if (e == ears - CNT_W'(1)) begin
              state <= S_DONE;
            end else begin
              e     <= e + CNT_W'(1);
              state <= S_EM_RD;
            end
          end
        end

        // Fan from point 0, one triangle a beat.
        S_FAN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_a     <= '0;
            out_b     <= IDX_W'(i);
            out_c     <= IDX_W'(i + CNT_W'(1));
            out_fan   <= 1'b1;
            out_drop  <= ovf;
            out_last  <= (i == n - CNT_W'(2));
            if (i == n - CNT_W'(2)) begin
              state <= S_DONE;
            end else begin
              i <= i + CNT_W'(1);
            end
          end
        end

        // Ready for the next loop.
        S_DONE: begin
          n     <= '0;
          ovf   <= 1'b0;
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/tb_polygon_ear_clip_triangulator_unit.sv =====
// Self-checking testbench for polygon_ear_clip_triangulator_unit: a directed table of
// vertex loops, then random loops, checked against a behavioral triangulation predictor.
// Depends on pect_pkg, pect_point_if, pect_tri_if and the block's RTL.
`timescale 1ns / 1ps

module tb_polygon_ear_clip_triangulator_unit;
  import pect_pkg::*;

  // Cycles allowed for a loop that ends without any triangle before the block is idle.
  localparam int QUIET_CYCLES = 30000;
  localparam int NUM_ITEMS    = 280;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic             fan;
    logic             dropped;
    logic             last_tri;
  } tri_res_t;

  // One row of the directed table; rows with has_exp carry a hand-derived triangle.
  typedef struct {
    int       x;
    int       y;
    bit       last;
    bit       has_exp;
    tri_res_t exp_tri;
  } vertex_row_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [SHIFT_W-1:0] cfg_write_data;

  pect_point_if points ();
  pect_tri_if   triangles ();

  polygon_ear_clip_triangulator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .points        (points),
    .triangles     (triangles)
  );

  // Predictor state.
  longint       vx [MAX_PTS];
  longint       vy [MAX_PTS];
  int           vcount;
  bit           overflowed;
  bit           area_neg;
  longint       tol_eps;
  int unsigned  tol_shift;
  int           ring_q [$];
  tri_res_t     ear_q [$];
  tri_res_t     expected_tris [$];
  vertex_row_t  table_rows [$];

  int  error_count;
  bit  no_idle;
  int  items_sent;
  int  stall_left;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic longint cross_at(int o, int a, int b);
    return (vx[a] - vx[o]) * (vy[b] - vy[o]) - (vy[a] - vy[o]) * (vx[b] - vx[o]);
  endfunction

  function automatic longint turn_at(int o, int a, int b);
    longint c;
    c = cross_at(o, a, b);
    return area_neg ? -c : c;
  endfunction

  function automatic tri_res_t make_tri(int a, int b, int c, bit fan);
    tri_res_t t;
    t.a = a[IDX_W-1:0];
    t.b = b[IDX_W-1:0];
    t.c = c[IDX_W-1:0];
    t.fan = fan;
    t.dropped = overflowed;
    t.last_tri = 1'b0;
    return t;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(int x, int y, bit last, bit has_exp, tri_res_t exp_tri);
    vertex_row_t row;
    row.x = x;
    row.y = y;
    row.last = last;
    row.has_exp = has_exp;
    row.exp_tri = exp_tri;
    table_rows = {table_rows, row};
  endfunction

  // Ear clipping over the index ring; -1 when no ear or flat corner can be removed.
  function automatic int clip_loop(int n);
    int     i, k, sz, ia, ib, ic, q;
    bit     done, covered;
    longint t, c;
    ear_q.delete();
    ring_q.delete();
    for (i = 0; i < n; i++) ring_q = {ring_q, i};
    while (ring_q.size() > 3) begin
      done = 0;
      for (i = 0; i < ring_q.size() && !done; i++) begin
        sz = ring_q.size();
        ia = ring_q[(i + sz - 1) % sz];
        ib = ring_q[i];
        ic = ring_q[(i + 1) % sz];
        t = turn_at(ia, ib, ic);
        if (t < -tol_eps) continue;
        // A flat corner leaves the ring without a triangle.
        if (t <= tol_eps) begin
          ring_q.delete(i);
          done = 1;
          break;
        end
        covered = 0;
        for (k = 0; k < sz; k++) begin
          q = ring_q[k];
          if (q == ia || q == ib || q == ic) continue;
          if (turn_at(ia, ib, q) >= -tol_eps && turn_at(ib, ic, q) >= -tol_eps &&
              turn_at(ic, ia, q) >= -tol_eps) begin
            covered = 1;
            break;
          end
        end
        if (covered) continue;
        ear_q = {ear_q, make_tri(ia, ib, ic, 1'b0)};
        ring_q.delete(i);
        done = 1;
      end
      if (!done) return -1;
    end
    // The closing triangle is skipped when it is flat within tolerance.
    c = cross_at(ring_q[0], ring_q[1], ring_q[2]);
    if (c < 0) c = -c;
    if (c > tol_eps) ear_q = {ear_q, make_tri(ring_q[0], ring_q[1], ring_q[2], 1'b0)};
    return ear_q.size();
  endfunction

  // Takes one accepted vertex beat and returns the triangles it causes.
  function automatic void triangulate_beat(int x, int y, bit last, ref tri_res_t res[$]);
    int          n, i, j, ears;
    longint      area;
    longint unsigned mag;
    bit          convex;
    res.delete();
    if (vcount < MAX_PTS) begin
      vx[vcount] = x;
      vy[vcount] = y;
      vcount++;
    end else begin
      overflowed = 1;
    end
    if (!last) return;
    n = vcount;
    if (n >= 3) begin
      area = 0;
      for (i = 0; i < n; i++) begin
        j = (i + 1) % n;
        area += vx[i] * vy[j] - vx[j] * vy[i];
      end
      area_neg = area < 0;
      mag = area_neg ? -area : area;
      tol_eps = longint'(mag >> tol_shift);
      ears = -1;
      if (n > 3) begin
        convex = 1;
        for (i = 0; i < n; i++)
          if (turn_at((i + n - 1) % n, i, (i + 1) % n) < -tol_eps) convex = 0;
        if (!convex) ears = clip_loop(n);
      end
      if (ears >= 0) begin
        res = {res, ear_q};
      end else begin
        for (i = 1; i + 1 < n; i++) res = {res, make_tri(0, i, i + 1, 1'b1)};
      end
      if (res.size() > 0) res[res.size() - 1].last_tri = 1'b1;
    end
    vcount = 0;
    overflowed = 0;
  endfunction

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drives one vertex beat, waits for acceptance and records the expected triangles.
  task automatic send_point(int x, int y, bit last, bit has_exp, tri_res_t exp_tri);
    int       gap;
    tri_res_t res [$];
    gap = gap_len();
    if (gap > 0) begin
      points.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    points.valid      <= 1'b1;
    points.point_x    <= x[COORD_W-1:0];
    points.point_y    <= y[COORD_W-1:0];
    points.last_point <= last;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
    triangulate_beat(x, y, last, res);
    if (has_exp) begin
      res.delete();
      res = {res, exp_tri};
    end
    expected_tris = {expected_tris, res};
    items_sent++;
  endtask

  task automatic drain_and_settle();
    points.valid <= 1'b0;
    while (expected_tris.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_shift(int unsigned value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value[SHIFT_W-1:0];
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    tol_shift = value;
  endtask

  // Star-shaped loop around a center: even angle steps with jitter and random radii,
  // so most loops are concave; optionally wound clockwise.
  task automatic send_star_loop(int n, int rmax);
    int  cx, cy, k, x, y, idx;
    real ang, rad;
    bit  cw;
    cx = $urandom_range(0, 16000) - 8000;
    cy = $urandom_range(0, 16000) - 8000;
    cw = $urandom_range(0, 1);
    for (k = 0; k < n; k++) begin
      idx = cw ? n - 1 - k : k;
      ang = 6.283185307 * (idx + 0.9 * $urandom_range(0, 1000) / 1000.0) / n;
      rad = rmax * (0.2 + 0.8 * $urandom_range(0, 1000) / 1000.0);
      x = cx + $rtoi(rad * $cos(ang));
      y = cy + $rtoi(rad * $sin(ang));
      send_point(x, y, k == n - 1, 1'b0, '0);
    end
  endtask

  // Loop with fully random coordinates over the whole field range.
  task automatic send_noise_loop(int n);
    int k;
    for (k = 0; k < n; k++)
      send_point($signed(16'($urandom)), $signed(16'($urandom)), k == n - 1, 1'b0, '0);
  endtask

  // Convex loop that overfills the store; the extra points, last one included, are dropped.
  task automatic send_overflow_loop();
    int k;
    for (k = 0; k < MAX_PTS + 3; k++)
      send_point($rtoi(30000.0 * $cos(6.283185307 * k / MAX_PTS)),
                 $rtoi(30000.0 * $sin(6.283185307 * k / MAX_PTS)),
                 k == MAX_PTS + 2, 1'b0, '0);
  endtask

  task automatic random_phase(int items);
    int stop_at, r;
    stop_at = items_sent + items;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 55)      send_star_loop($urandom_range(4, 8), $urandom_range(50, 20000));
      else if (r < 65) send_star_loop($urandom_range(4, 7), $urandom_range(2, 8));
      else if (r < 72) send_star_loop($urandom_range(9, 14), 20000);
      else if (r < 80) send_star_loop(3, $urandom_range(2, 20000));
      else if (r < 92) send_noise_loop($urandom_range(3, 7));
      else             send_noise_loop($urandom_range(1, 2));
    end
  endtask

  // Output side: random stalls, short mostly, with some long ones.
  always @(posedge clk) begin
    if (rst || no_idle) begin
      triangles.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      triangles.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      triangles.ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      triangles.ready <= 1'b1;
    end
  end

  // Each triangle beat is checked against the oldest expectation; the three flags
  // print as fan, dropped and last.
  always @(posedge clk) begin
    tri_res_t got, want;
    if (!rst && triangles.valid && triangles.ready) begin
      got = {triangles.corner_a, triangles.corner_b, triangles.corner_c,
             triangles.used_fan, triangles.points_dropped, triangles.last_triangle};
      if (expected_tris.size() == 0) begin
        $display("%0t: unexpected triangle beat %0d %0d %0d flags %0d%0d%0d",
                 $time, got.a, got.b, got.c, got.fan, got.dropped, got.last_tri);
        error_count++;
      end else begin
        want = expected_tris.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected %0d %0d %0d flags %0d%0d%0d, got %0d %0d %0d flags %0d%0d%0d",
                   $time, want.a, want.b, want.c, want.fan, want.dropped, want.last_tri,
                   got.a, got.b, got.c, got.fan, got.dropped, got.last_tri);
          error_count++;
        end
      end
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    tri_res_t    fan012;
    fan012 = '{a: 0, b: 1, c: 2, fan: 1'b1, dropped: 1'b0, last_tri: 1'b1};
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    points.valid = 1'b0;
    points.point_x = '0;
    points.point_y = '0;
    points.last_point = 1'b0;
    triangles.ready = 1'b1;
    error_count = 0;
    items_sent = 0;
    no_idle = 0;
    vcount = 0;
    overflowed = 0;
    area_neg = 0;
    tol_eps = 0;
    tol_shift = 20;

    // Extreme corners form a single triangle.
    add_row(-32768, -32768, 0, 0, '0);
    add_row(32767, -32768, 0, 0, '0);
    add_row(-32768, 32767, 1, 1, fan012);
    // Too few points: no triangle.
    add_row(5, 5, 0, 0, '0);
    add_row(6, 6, 1, 0, '0);
    add_row(7, -7, 1, 0, '0);
    // Notched square goes through ear clipping.
    add_row(0, 0, 0, 0, '0);
    add_row(10, 0, 0, 0, '0);
    add_row(10, 10, 0, 0, '0);
    add_row(5, 3, 0, 0, '0);
    add_row(0, 10, 1, 0, '0);
    // Notched loop with a flat vertex on the bottom edge.
    add_row(0, 0, 0, 0, '0);
    add_row(5, 0, 0, 0, '0);
    add_row(10, 0, 0, 0, '0);
    add_row(10, 10, 0, 0, '0);
    add_row(5, 2, 0, 0, '0);
    add_row(0, 10, 1, 0, '0);
    // Clockwise triangle.
    add_row(0, 0, 0, 0, '0);
    add_row(0, 100, 0, 0, '0);
    add_row(100, 0, 1, 1, fan012);
    // Zero-area triangle is still emitted as a fan.
    add_row(0, 0, 0, 0, '0);
    add_row(1, 1, 0, 0, '0);
    add_row(2, 2, 1, 1, fan012);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i])
      send_point(table_rows[i].x, table_rows[i].y, table_rows[i].last,
                 table_rows[i].has_exp, table_rows[i].exp_tri);
    drain_and_settle();

    // Random phases across tolerance settings, extremes included.
    write_shift(0);
    random_phase(50);
    drain_and_settle();
    write_shift(63);
    no_idle = 1;
    send_overflow_loop();
    random_phase(40);
    drain_and_settle();
    no_idle = 0;
    write_shift(40);
    random_phase(50);
    drain_and_settle();
    write_shift(20);
    random_phase(50);
    drain_and_settle();
    write_shift($urandom_range(1, 39));
    random_phase(NUM_ITEMS - items_sent > 20 ? NUM_ITEMS - items_sent : 20);
    drain_and_settle();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pect_pkg.sv
hw/rtl/pect_point_if.sv
hw/rtl/pect_tri_if.sv
hw/rtl/pect_ram.sv
hw/rtl/pect_cross.sv
hw/rtl/polygon_ear_clip_triangulator_unit.sv
sim/tb_polygon_ear_clip_triangulator_unit.sv
